// ----- design/scfla_pkg.sv -----
package scfla_pkg;

  localparam int GRANULE_SHIFT      = 2;
  localparam int GRANULE_BYTES      = 1 << GRANULE_SHIFT;
  localparam int MAX_BLOCK_BYTES    = 256;
  localparam int MIN_BLOCK_BYTES    = 8;
  localparam int CHUNK_BYTES        = 16384;
  localparam int REGION_BYTES       = 262144;

  localparam int NUM_CLASSES        = MAX_BLOCK_BYTES / GRANULE_BYTES;
  localparam int CLASS_W            = $clog2(NUM_CLASSES);
  localparam int NUM_GRANULES       = REGION_BYTES / GRANULE_BYTES;
  localparam int GRAN_W             = $clog2(NUM_GRANULES);
  localparam int LINK_W             = GRAN_W + 1;
  localparam int CHUNK_GRANULES     = CHUNK_BYTES / GRANULE_BYTES;
  localparam int CHUNK_OFF_W        = $clog2(CHUNK_GRANULES);
  localparam int NUM_CHUNKS         = REGION_BYTES / CHUNK_BYTES;
  localparam int CHUNK_IDX_W        = $clog2(NUM_CHUNKS);
  localparam int CHUNK_CNT_W        = CHUNK_IDX_W + 1;
  localparam int MIN_BLOCK_GRANULES = MIN_BLOCK_BYTES / GRANULE_BYTES;
  localparam int BLK_GRAN_W         = CLASS_W + 1;

  localparam int SIZE_W             = 12;
  localparam int ADDR_W             = 18;
  localparam int STATUS_W           = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                accept;
    logic                free_push;
    logic                pop_issue;
    logic                carve_start;
    logic                carve_step;
    logic                chain_read;
    logic                pop_done;
    logic                out_load;
    logic                out_addr;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic oversize;
    logic is_free;
    logic head_valid;
    logic chunks_full;
    logic carve_last;
  } sts_t;

endpackage

// ----- design/scfla_dpath.sv -----
module scfla_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mode,
  input  logic [scfla_pkg::SIZE_W-1:0]       size,
  input  logic [scfla_pkg::ADDR_W-1:0]       address,
  input  scfla_pkg::cmd_t                    cmd,
  output scfla_pkg::sts_t                    sts,
  output logic [scfla_pkg::ADDR_W-1:0]       address_res,
  output logic [scfla_pkg::STATUS_W-1:0]     status
);

  localparam int GW  = scfla_pkg::GRAN_W;
  localparam int LW  = scfla_pkg::LINK_W;
  localparam int CW  = scfla_pkg::CLASS_W;
  localparam int BW  = scfla_pkg::BLK_GRAN_W;
  localparam int OW  = scfla_pkg::CHUNK_OFF_W + 1;
  localparam int SUMW = scfla_pkg::SIZE_W + 1;

  logic                                mode_q;
  logic                                oversize_q;
  logic [CW-1:0]                       cls_q;
  logic [GW-1:0]                       gran_q;
  logic [GW-1:0]                       head_mem [scfla_pkg::NUM_CLASSES];
  logic [scfla_pkg::NUM_CLASSES-1:0]   head_vld;
  logic [GW-1:0]                       head_idx_q;
  logic                                head_v_q;
  logic [LW-1:0]                       link_mem [scfla_pkg::NUM_GRANULES];
  logic [LW-1:0]                       link_rdata;
  logic [scfla_pkg::CHUNK_CNT_W-1:0]   chunks_used;
  logic [scfla_pkg::CHUNK_IDX_W-1:0]   carve_chunk;
  logic [OW-1:0]                       carve_off;
  logic [LW-1:0]                       chain;

  logic [SUMW-1:0]                     size_sum;
  logic [SUMW-1:0]                     gran_cnt;
  logic [CW-1:0]                       cls_in;
  logic [BW-1:0]                       blk_gran;
  logic [GW-1:0]                       carve_gran;
  logic [OW:0]                         carve_reach;
  logic                                link_we;
  logic [GW-1:0]                       link_waddr;
  logic [LW-1:0]                       link_wdata;
  logic                                link_re;
  logic [GW-1:0]                       link_raddr;

  // The size class is the granule count rounded up, less one; a zero size maps to class zero.
  always_comb begin
    size_sum = SUMW'(size) + SUMW'(scfla_pkg::GRANULE_BYTES - 1);
    gran_cnt = size_sum >> scfla_pkg::GRANULE_SHIFT;
    cls_in   = (gran_cnt == '0) ? '0 : CW'(gran_cnt - SUMW'(1));
  end

  always_comb begin
    blk_gran = BW'(cls_q) + BW'(1);
    if (blk_gran < BW'(scfla_pkg::MIN_BLOCK_GRANULES)) begin
      blk_gran = BW'(scfla_pkg::MIN_BLOCK_GRANULES);
    end
    carve_gran  = {carve_chunk, carve_off[scfla_pkg::CHUNK_OFF_W-1:0]};
    carve_reach = (OW+1)'(carve_off) + (OW+1)'(blk_gran) + (OW+1)'(blk_gran);
  end

  always_comb begin
    sts.oversize    = oversize_q;
    sts.is_free     = (mode_q == scfla_pkg::MODE_FREE);
    sts.head_valid  = head_v_q;
    sts.chunks_full = chunks_used[scfla_pkg::CHUNK_CNT_W-1];
    sts.carve_last  = carve_reach > (OW+1)'(scfla_pkg::CHUNK_GRANULES);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q     <= mode;
      oversize_q <= size > scfla_pkg::SIZE_W'(scfla_pkg::MAX_BLOCK_BYTES);
      cls_q      <= cls_in;
      gran_q     <= address[scfla_pkg::ADDR_W-1:scfla_pkg::GRANULE_SHIFT];
    end
  end

  // List heads: index memory plus one valid flop per class.
  always_ff @(posedge clk) begin
    if (cmd.free_push) begin
      head_mem[cls_q] <= gran_q;
    end else if (cmd.pop_done) begin
      head_mem[cls_q] <= link_rdata[GW-1:0];
    end
    if (cmd.accept) begin
      head_idx_q <= head_mem[cls_in];
      head_v_q   <= head_vld[cls_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
    end else if (cmd.free_push) begin
      head_vld[cls_q] <= 1'b1;
    end else if (cmd.pop_done) begin
      head_vld[cls_q] <= link_rdata[LW-1];
    end
  end

  // Link store: one write and one registered read per cycle.
  always_comb begin
    link_we    = cmd.free_push | cmd.carve_step;
    link_waddr = cmd.free_push ? gran_q : carve_gran;
    link_wdata = cmd.free_push ? {head_v_q, (head_v_q ? head_idx_q : GW'(0))} : chain;
    link_re    = cmd.pop_issue | cmd.chain_read;
    link_raddr = cmd.pop_issue ? head_idx_q : chain[GW-1:0];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_used <= '0;
    end else if (cmd.carve_start) begin
      chunks_used <= chunks_used + scfla_pkg::CHUNK_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.carve_start) begin
      carve_chunk <= chunks_used[scfla_pkg::CHUNK_IDX_W-1:0];
      carve_off   <= '0;
    end else if (cmd.carve_step) begin
      carve_off <= carve_off + OW'(blk_gran);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_issue) begin
      chain <= {1'b1, head_idx_q};
    end else if (cmd.carve_start) begin
      chain <= '0;
    end else if (cmd.carve_step) begin
      chain <= {1'b1, carve_gran};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      address_res <= cmd.out_addr ?
                     {chain[GW-1:0], scfla_pkg::GRANULE_SHIFT'(0)} : '0;
    end
  end

endmodule

// ----- design/scfla_ctrl.sv -----
module scfla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  scfla_pkg::sts_t sts,
  output scfla_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOOKUP   = 3'd1;
  localparam logic [2:0] S_CARVE    = 3'd2;
  localparam logic [2:0] S_CHAIN_RD = 3'd3;
  localparam logic [2:0] S_POP      = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        priority if (sts.oversize) begin
          if (out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = scfla_pkg::ST_OVERSIZE;
            state_next     = S_IDLE;
          end
        end else if (sts.is_free) begin
          if (out_free) begin
            cmd.free_push  = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_status = scfla_pkg::ST_OK;
            state_next     = S_IDLE;
          end
        end else if (sts.head_valid) begin
          cmd.pop_issue = 1'b1;
          state_next    = S_POP;
        end else if (sts.chunks_full) begin
          if (out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = scfla_pkg::ST_OOM;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.carve_start = 1'b1;
          state_next      = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd.carve_step = 1'b1;
        if (sts.carve_last) begin
          state_next = S_CHAIN_RD;
        end
      end
      S_CHAIN_RD: begin
        cmd.chain_read = 1'b1;
        state_next     = S_POP;
      end
      S_POP: begin
        if (out_free) begin
          cmd.pop_done   = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_addr   = 1'b1;
          cmd.out_status = scfla_pkg::ST_OK;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load || (out_valid && !out_ready);
    end
  end

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded while the previous beat was still held");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOOKUP))
    else $error("accepted beat did not move to lookup");

  a_carve_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.carve_start |-> !sts.chunks_full)
    else $error("carve started with the region exhausted");

  a_carve_end_reads_chain: assert property (@(posedge clk) disable iff (rst)
    (state == S_CARVE && sts.carve_last) |=> (state == S_CHAIN_RD))
    else $error("carve end did not read the new list head");

endmodule

// ----- design/size_class_free_list_allocator_unit.sv -----
// Segregated free-list allocator over an 18-bit byte region, with one LIFO list per
// 4-byte size class, one request at a time. A free, an oversize request or an
// out-of-memory reply is answered from the lookup state; an allocation served from
// its list is answered after the registered head read and then the registered link read.
// An allocation that finds its list empty first carves the next 16 KiB chunk
// at one link-store write per block, then reads the last block's link and hands it out.
// A result that is not taken does not stop the next request from being accepted; that
// request is worked up to its own result and then waits until the held beat is taken.
module size_class_free_list_allocator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [scfla_pkg::SIZE_W-1:0]       size,
  input  logic [scfla_pkg::ADDR_W-1:0]       address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scfla_pkg::ADDR_W-1:0]       address_res,
  output logic [scfla_pkg::STATUS_W-1:0]     status
);

  scfla_pkg::cmd_t cmd;
  scfla_pkg::sts_t sts;

  scfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scfla_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .size        (size),
    .address     (address),
    .cmd         (cmd),
    .sts         (sts),
    .address_res (address_res),
    .status      (status)
  );

endmodule
